// ===== rtl/hcb_pkg.sv =====
package hcb_pkg;

  localparam int SYMBOLS   = 256;
  localparam int MAX_NODES = 2 * SYMBOLS - 1;
  localparam int SYM_W     = $clog2(SYMBOLS);
  localparam int CNT_W     = $clog2(SYMBOLS + 1);
  localparam int NODE_W    = 9;
  localparam int TOTAL_W   = NODE_W + 1;
  localparam int WGT_W     = 40;
  localparam int CODE_W    = 64;
  localparam int LEN_W     = 6;
  localparam int MAX_LEN   = 63;

  localparam logic [NODE_W-1:0] NO_PARENT = '1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_TREE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_t;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_BUILD,
    S_SCAN,
    S_DRAIN,
    S_LINK_A,
    S_LINK_B,
    S_NEW,
    S_CODE_ISSUE,
    S_CODE_STEP
  } state_t;

  typedef struct packed {
    logic        func;
    logic [31:0] weight;
    logic        last;
    logic [7:0]  symbol;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] parent;
    logic              right;
  } link_t;

  typedef struct packed {
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [WGT_W-1:0]  wa;
    logic [WGT_W-1:0]  wb;
  } pick_t;

endpackage

// ===== rtl/huffman_code_builder.sv =====
// Load item: no result; an overflow load gives its result on the next cycle.
// Read item: the code memory read and then the result are registered; input stalls until done.
// Last load starts a build over n symbols: per new node, a scan for the two lightest
// parentless nodes, then linking both children and writing the node; then a leaf-to-root
// code walk per symbol; input stalls meanwhile.
// Reset (rst, synchronous) clears counts, tree-ready flag and output valid; memories
// are not cleared.
module huffman_code_builder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hcb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hcb_pkg::out_item_t out_data
);
  import hcb_pkg::*;

  logic [WGT_W-1:0]   node_w [MAX_NODES];
  link_t              node_l [MAX_NODES];
  logic [LEN_W+CODE_W-1:0] code_mem [SYMBOLS];

  state_t state, state_next;
  logic [CNT_W-1:0]   count;
  logic               tree_ready;
  logic [NODE_W-1:0]  i;
  logic [NODE_W-1:0]  k;
  logic               rv;
  logic [NODE_W-1:0]  rk;
  logic [NODE_W-1:0]  cur;
  logic [NODE_W-1:0]  depth;
  logic [CODE_W-1:0]  bits;
  logic [SYM_W-1:0]   s;
  status_t            rd_status;

  logic [WGT_W-1:0]   w_rd;
  link_t              l_rd;
  logic [LEN_W+CODE_W-1:0] c_rd;

  logic               acc;
  logic [CNT_W-1:0]   eff;
  logic               fits;
  logic [CNT_W-1:0]   new_count;
  logic [TOTAL_W-1:0] total;
  logic               scan_end;
  logic               nodes_done;
  logic               sym_done;
  logic               out_set;

  logic               nw_we;
  logic [NODE_W-1:0]  nw_addr;
  logic [WGT_W-1:0]   nw_data;
  logic               nl_we;
  logic [NODE_W-1:0]  nl_addr;
  link_t              nl_data;
  logic [NODE_W-1:0]  n_raddr;
  logic               cm_we;
  logic               tr_clear;
  logic               tr_upd;
  pick_t              pick;

  hcb_min2 u_min2 (
    .clk  (clk),
    .rst  (rst),
    .clear(tr_clear),
    .upd  (tr_upd),
    .idx  (rk),
    .w    (w_rd),
    .pick (pick)
  );

  assign in_stall   = (state != S_IDLE) || (out_valid && out_stall);
  assign acc        = in_valid && !in_stall;
  assign eff        = tree_ready ? '0 : count;
  assign fits       = eff < CNT_W'(SYMBOLS);
  assign new_count  = fits ? eff + 1'b1 : eff;
  assign total      = {count, 1'b0} - 1'b1;
  assign scan_end   = (k == i - 1'b1);
  assign nodes_done = ({1'b0, i} + 1'b1 == total);
  assign sym_done   = ({1'b0, s} + 1'b1 == count);
  assign tr_upd     = rv && (l_rd.parent == NO_PARENT);
  assign out_set    = (state == S_READ) || (acc && in_data.func == FUNC_LOAD && !fits);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (in_data.func == FUNC_READ) state_next = S_READ;
          else if (in_data.last) state_next = S_BUILD;
        end
      end
      S_READ:   state_next = S_IDLE;
      S_BUILD:  state_next = (count == CNT_W'(1)) ? S_CODE_ISSUE : S_SCAN;
      S_SCAN:   if (scan_end) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_LINK_A;
      S_LINK_A: state_next = S_LINK_B;
      S_LINK_B: state_next = S_NEW;
      S_NEW:    state_next = nodes_done ? S_CODE_ISSUE : S_SCAN;
      S_CODE_ISSUE: state_next = S_CODE_STEP;
      S_CODE_STEP: begin
        if (l_rd.parent == NO_PARENT && sym_done) state_next = S_IDLE;
        else state_next = S_CODE_ISSUE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    nw_we    = 1'b0;
    nw_addr  = i;
    nw_data  = pick.wa + pick.wb;
    nl_we    = 1'b0;
    nl_addr  = i;
    nl_data  = '{parent: NO_PARENT, right: 1'b0};
    n_raddr  = k;
    cm_we    = 1'b0;
    tr_clear = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc && in_data.func == FUNC_LOAD && fits) begin
          nw_we   = 1'b1;
          nl_we   = 1'b1;
          nw_addr = NODE_W'(eff);
          nl_addr = NODE_W'(eff);
          nw_data = WGT_W'(in_data.weight);
        end
      end
      S_BUILD: tr_clear = 1'b1;
      S_LINK_A: begin
        nl_we   = 1'b1;
        nl_addr = pick.a;
        nl_data = '{parent: i, right: 1'b0};
      end
      S_LINK_B: begin
        nl_we   = 1'b1;
        nl_addr = pick.b;
        nl_data = '{parent: i, right: 1'b1};
      end
      S_NEW: begin
        nw_we    = 1'b1;
        nl_we    = 1'b1;
        tr_clear = 1'b1;
      end
      S_CODE_ISSUE: n_raddr = cur;
      S_CODE_STEP:  cm_we = (l_rd.parent == NO_PARENT);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nw_we) node_w[nw_addr] <= nw_data;
    if (nl_we) node_l[nl_addr] <= nl_data;
    w_rd <= node_w[n_raddr];
    l_rd <= node_l[n_raddr];
    if (cm_we) begin
      code_mem[s] <= {(depth > NODE_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : depth[LEN_W-1:0], bits};
    end
    c_rd <= code_mem[in_data.symbol];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      tree_ready <= 1'b0;
      out_valid  <= 1'b0;
      rv         <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= (state == S_SCAN);
      if (out_set) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (in_data.func == FUNC_LOAD) begin
              tree_ready <= 1'b0;
              count      <= new_count;
              if (!fits) begin
                out_data  <= '{code_bits: '0, code_length: '0, status: STAT_RANGE};
              end
            end else begin
              if (!tree_ready) rd_status <= STAT_NO_TREE;
              else if ({1'b0, in_data.symbol} >= count) rd_status <= STAT_RANGE;
              else rd_status <= STAT_OK;
            end
          end
        end
        S_READ: begin
          out_data.status <= rd_status;
          if (rd_status == STAT_OK) begin
            out_data.code_bits   <= c_rd[CODE_W-1:0];
            out_data.code_length <= c_rd[LEN_W+CODE_W-1:CODE_W];
          end else begin
            out_data.code_bits   <= '0;
            out_data.code_length <= '0;
          end
        end
        S_BUILD: begin
          i     <= NODE_W'(count);
          k     <= '0;
          s     <= '0;
          cur   <= '0;
          depth <= '0;
          bits  <= '0;
        end
        S_SCAN: begin
          k  <= k + 1'b1;
          rk <= k;
        end
        S_NEW: begin
          i <= i + 1'b1;
          k <= '0;
        end
        S_CODE_STEP: begin
          if (l_rd.parent == NO_PARENT) begin
            if (sym_done) tree_ready <= 1'b1;
            s     <= s + 1'b1;
            cur   <= NODE_W'(s) + 1'b1;
            depth <= '0;
            bits  <= '0;
          end else begin
            if (depth < NODE_W'(MAX_LEN) && l_rd.right) bits[depth[LEN_W-1:0]] <= 1'b1;
            depth <= depth + 1'b1;
            cur   <= l_rd.parent;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/hcb_min2.sv =====
module hcb_min2 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      upd,
  input  logic [hcb_pkg::NODE_W-1:0] idx,
  input  logic [hcb_pkg::WGT_W-1:0]  w,
  output hcb_pkg::pick_t            pick
);
  import hcb_pkg::*;

  logic have1;
  logic have2;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      have1 <= 1'b0;
      have2 <= 1'b0;
    end else if (upd) begin
      if (!have1 || w < pick.wa) begin
        have1   <= 1'b1;
        have2   <= have1;
        pick.b  <= pick.a;
        pick.wb <= pick.wa;
        pick.a  <= idx;
        pick.wa <= w;
      end else if (!have2 || w < pick.wb) begin
        have2   <= 1'b1;
        pick.b  <= idx;
        pick.wb <= w;
      end
    end
  end

endmodule

// ===== rtl/hcb_checker.sv =====
module hcb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input hcb_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input hcb_pkg::out_item_t out_data
);
  import hcb_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_NO_TREE ||
                   out_data.status == STAT_RANGE))
    else $error("bad status code");

  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != STAT_OK) |->
      (out_data.code_bits == '0 && out_data.code_length == '0))
    else $error("error item carries a code");

  a_read_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.func == FUNC_READ) |=> in_stall)
    else $error("read not followed by stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled item changed");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (.*);

// ===== tb/sv/hcb_checker.sv =====
`timescale 1ns / 1ps

module tb_hcb_checker
  import hcb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fails,
  output int        pending
);

  logic [WGT_W-1:0]  tree_weight [MAX_NODES];
  int                tree_parent [MAX_NODES];
  int                tree_left   [MAX_NODES];
  logic [CODE_W-1:0] code_table  [SYMBOLS];
  int                len_table   [SYMBOLS];
  int                loaded;
  bit                built;
  out_item_t         expected_codes[$];

  function automatic int lightest(int lim);
    int best;
    bit found;
    best = 0;
    found = 0;
    for (int k = 0; k < lim; k++) begin
      if (tree_parent[k] != MAX_NODES) continue;
      if (!found || tree_weight[k] < tree_weight[best]) begin
        best = k;
        found = 1;
      end
    end
    return best;
  endfunction

  task automatic build_codes();
    int n, total, a, b, cur, up, depth;
    logic [CODE_W-1:0] bits;
    n = loaded;
    for (int i = 0; i < n; i++) tree_parent[i] = MAX_NODES;
    total = (n == 0) ? 0 : 2 * n - 1;
    for (int i = n; i < total; i++) begin
      a = lightest(i);
      tree_parent[a] = i;
      b = lightest(i);
      tree_parent[b] = i;
      tree_left[i] = a;
      tree_weight[i] = tree_weight[a] + tree_weight[b];
      tree_parent[i] = MAX_NODES;
    end
    for (int s = 0; s < n; s++) begin
      bits = '0;
      depth = 0;
      cur = s;
      while (depth < MAX_NODES && cur < MAX_NODES) begin
        up = tree_parent[cur];
        if (up >= MAX_NODES) break;
        if (depth < MAX_LEN && tree_left[up] != cur) bits[depth] = 1'b1;
        depth++;
        cur = up;
      end
      code_table[s] = bits;
      len_table[s] = (depth > MAX_LEN) ? MAX_LEN : depth;
    end
    built = 1;
  endtask

  function automatic out_item_t code_result(logic [CODE_W-1:0] bits, int len, status_t st);
    out_item_t r;
    r.code_bits = bits;
    r.code_length = len[LEN_W-1:0];
    r.status = st;
    return r;
  endfunction

  task automatic apply_item(in_item_t it);
    if (it.func == FUNC_LOAD) begin
      if (built) begin
        built = 0;
        loaded = 0;
      end
      if (loaded < SYMBOLS) begin
        tree_weight[loaded] = {8'd0, it.weight};
        loaded++;
      end else begin
        expected_codes.push_back(code_result('0, 0, STAT_RANGE));
      end
      if (it.last) build_codes();
    end else if (!built) begin
      expected_codes.push_back(code_result('0, 0, STAT_NO_TREE));
    end else if (it.symbol >= loaded) begin
      expected_codes.push_back(code_result('0, 0, STAT_RANGE));
    end else begin
      expected_codes.push_back(code_result(code_table[it.symbol], len_table[it.symbol],
                                           STAT_OK));
    end
  endtask

  task automatic report_miss(string what, out_item_t got, out_item_t want);
    $display("mismatch %s: got bits=%h len=%0d st=%0d, want bits=%h len=%0d st=%0d",
             what, got.code_bits, got.code_length, got.status,
             want.code_bits, want.code_length, want.status);
    fails++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      fails = 0;
      loaded = 0;
      built = 0;
      expected_codes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          report_miss("unexpected item", out_data, '0);
        end else begin
          want = expected_codes.pop_front();
          if (out_data.code_bits !== want.code_bits)
            report_miss("code_bits", out_data, want);
          if (out_data.code_length !== want.code_length)
            report_miss("code_length", out_data, want);
          if (out_data.status !== want.status)
            report_miss("status", out_data, want);
        end
      end
      if (in_valid && !in_stall) apply_item(in_data);
    end
    pending = expected_codes.size();
  end

endmodule

// ===== tb/sv/tb_huffman_code_builder.sv =====
`timescale 1ns / 1ps

module tb_huffman_code_builder;
  import hcb_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fails;
  int        pending;
  int        cycles;
  int        sent;
  bit        calm;
  int        hold_req;
  int        hold_seen;
  int        hold_left;

  huffman_code_builder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  tb_hcb_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fails(fails), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    out_stall <= 1'b0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 38);
      end
    end
  end

  function automatic in_item_t mk(func_t f, logic [31:0] w, logic l, logic [7:0] s);
    in_item_t it;
    it.func = f;
    it.weight = w;
    it.last = l;
    it.symbol = s;
    return it;
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return $urandom_range(7);
      2: return $urandom;
      default: return 32'hFFFF_FFFF - $urandom_range(3);
    endcase
  endfunction

  task automatic offer(in_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 38) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic load(logic [31:0] w, logic l);
    offer(mk(FUNC_LOAD, w, l, 8'($urandom)));
  endtask

  task automatic read(logic [7:0] s);
    offer(mk(FUNC_READ, $urandom, 1'($urandom), s));
  endtask

  initial begin
    int n, k, round;
    logic [31:0] fa, fb, fc;
    rst = 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    calm = 0;
    hold_req = 0;
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    read(8'd0);
    read(8'd255);
    load(32'd0, 1'b1);
    read(8'd0);
    read(8'd1);
    load(32'hFFFF_FFFF, 1'b0);
    load(32'd0, 1'b0);
    load(32'hFFFF_FFFF, 1'b0);
    read(8'd2);
    load(32'd1, 1'b1);
    for (int s = 0; s < 4; s++) read(s[7:0]);
    read(8'd255);
    load(32'd5, 1'b0);
    load(32'd5, 1'b0);
    load(32'd5, 1'b1);
    read(8'd0);
    read(8'd1);
    read(8'd2);

    round = 0;
    while (sent < 830) begin
      round++;
      calm = (round >= 6 && round <= 8);
      if (round == 6) begin
        for (int s = 0; s < 256; s++) load($urandom, 1'b0);
        load($urandom, 1'b0);
        load($urandom, 1'b1);
        n = 256;
      end else if (round == 12) begin
        fa = 32'd1;
        fb = 32'd1;
        for (int s = 0; s < 46; s++) begin
          load(fa, s == 45);
          fc = fa + fb;
          fa = fb;
          fb = fc;
        end
        n = 46;
      end else begin
        n = $urandom_range(2, 12);
        for (int s = 0; s < n; s++) begin
          if ($urandom_range(9) == 0) read(8'($urandom));
          load(rand_weight(), s == n - 1);
        end
      end
      if (sent > 500 && round % 7 == 0) hold_req++;
      k = $urandom_range(n, 2 * n);
      if (k > 30) k = 30;
      for (int j = 0; j < k; j++) begin
        if ($urandom_range(9) == 0) read(8'($urandom));
        else read(8'($urandom_range(n - 1)));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
